/* design/prrs_pkg.sv */
// Shared widths, limits and control/status types of the thread scheduler.
`default_nettype none
package prrs_pkg;

  localparam int MaxThreads = 64;
  localparam int MaxPrio    = 5;
  localparam int MaxEvents  = 256;

  localparam int NumPrio = MaxPrio + 1;
  localparam int TidW    = $clog2(MaxThreads);
  localparam int CntW    = $clog2(MaxThreads + 1);
  localparam int PrioW   = 3;
  localparam int EvW     = 8;
  localparam int NevW    = 9;
  localparam int QuantW  = 16;
  localparam int ReqW    = 3;
  localparam int StatW   = 2;
  localparam int TstW    = 3;
  localparam int CfgIdxW = 1;
  localparam int CfgW    = 16;
  localparam int WaitW   = TidW + EvW + PrioW;

  // Request type codes.
  localparam logic [ReqW-1:0] ReqCreate = 3'd0;
  localparam logic [ReqW-1:0] ReqTick   = 3'd1;
  localparam logic [ReqW-1:0] ReqWait   = 3'd2;
  localparam logic [ReqW-1:0] ReqSignal = 3'd3;
  localparam logic [ReqW-1:0] ReqFinish = 3'd4;

  // Result status codes.
  localparam logic [StatW-1:0] StBadPrio = 2'd1;
  localparam logic [StatW-1:0] StBadEv   = 2'd2;
  localparam logic [StatW-1:0] StFull    = 2'd3;

  // Thread state reported for the running thread.
  localparam logic [TstW-1:0] TstRunning = 3'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             latch;
    logic             create;
    logic             wait_push;
    logic             yield;
    logic             scan_init;
    logic             scan_chk;
    logic             scan_end;
    logic             consume;
    logic             disp_rd;
    logic             reins_sel;
    logic             disp_done;
    logic             reins;
    logic             idle_cpu;
    logic             refill;
    logic             status_wr;
    logic [StatW-1:0] status_val;
    logic             out_load;
  } prrs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [ReqW-1:0] req;
    logic            bad_prio;
    logic            full;
    logic            bad_ev;
    logic            cur_valid;
    logic            yielding;
    logic            rdy_any;
    logic            preempt;
    logic            scan_more;
    logic            reins_pend;
    logic            out_free;
  } prrs_stat_t;

endpackage
`default_nettype wire

/* design/prrs_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none
module prrs_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

/* design/prrs_ctrl.sv */
// Controller state machine that sequences each scheduler request.
`default_nettype none
module prrs_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire prrs_pkg::prrs_stat_t stat_i,
  output prrs_pkg::prrs_cmd_t       cmd_o
);
  import prrs_pkg::*;

  localparam logic [3:0] SIdle     = 4'd0;
  localparam logic [3:0] SDec      = 4'd1;
  localparam logic [3:0] SScanRd   = 4'd2;
  localparam logic [3:0] SScanChk  = 4'd3;
  localparam logic [3:0] SCons     = 4'd4;
  localparam logic [3:0] SResched  = 4'd5;
  localparam logic [3:0] SDispRd   = 4'd6;
  localparam logic [3:0] SDispDone = 4'd7;
  localparam logic [3:0] SReins    = 4'd8;
  localparam logic [3:0] SFin      = 4'd9;

  logic [3:0] state_q, state_d;

  assign in_stall_o = (state_q != SIdle);

  // Next state and command decode.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = SDec;
        end
      end
      SDec: begin
        state_d = SFin;
        case (stat_i.req)
          ReqCreate: begin
            if (stat_i.bad_prio) begin
              cmd_o.status_wr  = 1'b1;
              cmd_o.status_val = StBadPrio;
            end else if (stat_i.full) begin
              cmd_o.status_wr  = 1'b1;
              cmd_o.status_val = StFull;
            end else begin
              cmd_o.create = 1'b1;
              state_d      = SCons;
            end
          end
          ReqTick: begin
            if (stat_i.cur_valid) state_d = SCons;
          end
          ReqWait: begin
            if (stat_i.bad_ev) begin
              cmd_o.status_wr  = 1'b1;
              cmd_o.status_val = StBadEv;
            end else if (stat_i.cur_valid) begin
              cmd_o.wait_push = 1'b1;
              cmd_o.yield     = 1'b1;
              state_d         = SCons;
            end
          end
          ReqSignal: begin
            if (stat_i.bad_ev) begin
              cmd_o.status_wr  = 1'b1;
              cmd_o.status_val = StBadEv;
            end else begin
              cmd_o.scan_init = 1'b1;
              state_d         = SScanRd;
            end
          end
          ReqFinish: begin
            if (stat_i.cur_valid) begin
              cmd_o.yield = 1'b1;
              state_d     = SResched;
            end
          end
          default: state_d = SFin;
        endcase
      end
      SScanRd: begin
        if (stat_i.scan_more) begin
          state_d = SScanChk;
        end else begin
          cmd_o.scan_end = 1'b1;
          state_d        = SCons;
        end
      end
      SScanChk: begin
        cmd_o.scan_chk = 1'b1;
        state_d        = SScanRd;
      end
      SCons: begin
        cmd_o.consume = 1'b1;
        state_d       = SResched;
      end
      SResched: begin
        state_d = SFin;
        if (!stat_i.cur_valid || stat_i.yielding) begin
          if (stat_i.rdy_any) begin
            cmd_o.disp_rd = 1'b1;
            state_d       = SDispRd;
          end else begin
            cmd_o.idle_cpu = 1'b1;
          end
        end else if (stat_i.preempt) begin
          cmd_o.disp_rd   = 1'b1;
          cmd_o.reins_sel = 1'b1;
          state_d         = SDispRd;
        end else begin
          cmd_o.refill = 1'b1;
        end
      end
      SDispRd: begin
        state_d = SDispDone;
      end
      SDispDone: begin
        cmd_o.disp_done = 1'b1;
        state_d         = stat_i.reins_pend ? SReins : SFin;
      end
      SReins: begin
        cmd_o.reins = 1'b1;
        state_d     = SFin;
      end
      SFin: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

/* design/prrs_datapath.sv */
// Datapath: running thread, per-priority ready lists, wait list and result register.
`default_nettype none
module prrs_datapath (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [prrs_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  wire logic [prrs_pkg::CfgW-1:0]        cfg_data_i,
  input  wire logic [prrs_pkg::ReqW-1:0]        req_type_i,
  input  wire logic [prrs_pkg::PrioW-1:0]       priority_req_i,
  input  wire logic [prrs_pkg::EvW-1:0]         event_id_i,
  input  wire logic                             out_stall_i,
  output logic                                  out_valid_o,
  output logic      [prrs_pkg::StatW-1:0]       status_o,
  output logic                                  running_valid_o,
  output logic      [prrs_pkg::TidW-1:0]        running_id_o,
  output logic      [prrs_pkg::TstW-1:0]        running_state_o,
  output logic      [prrs_pkg::TidW-1:0]        new_id_o,
  output logic      [prrs_pkg::CntW-1:0]        woken_count_o,
  input  wire prrs_pkg::prrs_cmd_t              cmd_i,
  output prrs_pkg::prrs_stat_t                  stat_o
);
  import prrs_pkg::*;

  // Configuration and control registers.
  logic [QuantW-1:0] quantum_q;
  logic [NevW-1:0]   num_events_q;
  logic [CntW-1:0]   thread_count_q;
  logic [CntW-1:0]   wait_count_q;
  logic              cur_valid_q;
  logic              yield_q;
  logic              reins_q;
  logic [NumPrio-1:0] ne_q;
  logic              out_valid_q;

  // Payload registers.
  logic [ReqW-1:0]   req_q;
  logic [PrioW-1:0]  prio_q;
  logic [EvW-1:0]    ev_q;
  logic [StatW-1:0]  status_q;
  logic [TidW-1:0]   new_id_q;
  logic [CntW-1:0]   woken_q;
  logic [TidW-1:0]   cur_id_q;
  logic [PrioW-1:0]  cur_prio_q;
  logic [QuantW-1:0] cur_time_q;
  logic [TidW-1:0]   old_id_q;
  logic [PrioW-1:0]  old_prio_q;
  logic [CntW-1:0]   scan_idx_q;
  logic [CntW-1:0]   kept_q;
  logic [TidW-1:0]   head_q [NumPrio];
  logic [TidW-1:0]   tail_q [NumPrio];
  logic [StatW-1:0]  o_status_q;
  logic              o_rvalid_q;
  logic [TidW-1:0]   o_rid_q;
  logic [TstW-1:0]   o_rstate_q;
  logic [TidW-1:0]   o_new_id_q;
  logic [CntW-1:0]   o_woken_q;

  // Memory ports.
  logic [TidW-1:0]   next_rdata;
  logic              next_we;
  logic [WaitW-1:0]  wait_rdata;
  logic              wait_we;
  logic [TidW-1:0]   wait_waddr;
  logic [WaitW-1:0]  wait_wdata;

  logic [TidW-1:0]   rd_id;
  logic [EvW-1:0]    rd_ev;
  logic [PrioW-1:0]  rd_prio;
  logic              match;
  logic [PrioW-1:0]  hp;
  logic [QuantW-1:0] full_q;
  logic              ins_en;
  logic [TidW-1:0]   ins_id;
  logic [PrioW-1:0]  ins_prio;

  assign {rd_id, rd_ev, rd_prio} = wait_rdata;
  assign match  = (rd_ev == ev_q);
  assign full_q = (quantum_q == '0) ? QuantW'(1) : quantum_q;

  // Highest priority with a non-empty ready list.
  always_comb begin
    hp = '0;
    for (int i = 0; i < NumPrio; i++) begin
      if (ne_q[i]) hp = PrioW'(i);
    end
  end

  // Ready-list insertion source.
  always_comb begin
    ins_en   = 1'b0;
    ins_id   = thread_count_q[TidW-1:0];
    ins_prio = prio_q;
    if (cmd_i.create) begin
      ins_en = 1'b1;
    end else if (cmd_i.scan_chk && match) begin
      ins_en   = 1'b1;
      ins_id   = rd_id;
      ins_prio = rd_prio;
    end else if (cmd_i.reins) begin
      ins_en   = 1'b1;
      ins_id   = old_id_q;
      ins_prio = old_prio_q;
    end
  end

  assign next_we = ins_en && ne_q[ins_prio];

  // Wait-list write: a new waiter is appended, a kept entry is compacted.
  always_comb begin
    wait_we    = 1'b0;
    wait_waddr = kept_q[TidW-1:0];
    wait_wdata = wait_rdata;
    if (cmd_i.wait_push) begin
      wait_we    = 1'b1;
      wait_waddr = wait_count_q[TidW-1:0];
      wait_wdata = {cur_id_q, ev_q, cur_prio_q};
    end else if (cmd_i.scan_chk && !match) begin
      wait_we = 1'b1;
    end
  end

  prrs_ram #(.Width(TidW), .Depth(MaxThreads)) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (next_we),
    .waddr_i (tail_q[ins_prio]),
    .wdata_i (ins_id),
    .raddr_i (head_q[hp]),
    .rdata_o (next_rdata)
  );

  prrs_ram #(.Width(WaitW), .Depth(MaxThreads)) u_wait_ram (
    .clk_i   (clk_i),
    .we_i    (wait_we),
    .waddr_i (wait_waddr),
    .wdata_i (wait_wdata),
    .raddr_i (scan_idx_q[TidW-1:0]),
    .rdata_o (wait_rdata)
  );

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quantum_q      <= QuantW'(1);
      num_events_q   <= NevW'(MaxEvents);
      thread_count_q <= '0;
      wait_count_q   <= '0;
      cur_valid_q    <= 1'b0;
      yield_q        <= 1'b0;
      reins_q        <= 1'b0;
      ne_q           <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CfgIdxW'(0)) quantum_q <= cfg_data_i;
        else num_events_q <= cfg_data_i[NevW-1:0];
      end
      if (cmd_i.create) thread_count_q <= thread_count_q + CntW'(1);
      if (cmd_i.wait_push) wait_count_q <= wait_count_q + CntW'(1);
      if (cmd_i.scan_end) wait_count_q <= kept_q;
      if (cmd_i.yield) yield_q <= 1'b1;
      if (cmd_i.disp_rd) reins_q <= cmd_i.reins_sel;
      if (cmd_i.disp_done) begin
        cur_valid_q <= 1'b1;
        yield_q     <= 1'b0;
        if (head_q[hp] == tail_q[hp]) ne_q[hp] <= 1'b0;
      end
      if (cmd_i.idle_cpu) begin
        cur_valid_q <= 1'b0;
        yield_q     <= 1'b0;
      end
      if (ins_en) ne_q[ins_prio] <= 1'b1;
      if (cmd_i.out_load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      req_q    <= req_type_i;
      prio_q   <= priority_req_i;
      ev_q     <= event_id_i;
      status_q <= '0;
      new_id_q <= '0;
      woken_q  <= '0;
    end
    if (cmd_i.status_wr) status_q <= cmd_i.status_val;
    if (cmd_i.create) new_id_q <= thread_count_q[TidW-1:0];
    if (cmd_i.scan_init) begin
      scan_idx_q <= '0;
      kept_q     <= '0;
    end
    if (cmd_i.scan_chk) begin
      scan_idx_q <= scan_idx_q + CntW'(1);
      if (match) woken_q <= woken_q + CntW'(1);
      else kept_q <= kept_q + CntW'(1);
    end
    if (cmd_i.consume && cur_valid_q && cur_time_q != '0) begin
      cur_time_q <= cur_time_q - QuantW'(1);
    end
    if (cmd_i.refill && cur_time_q == '0) cur_time_q <= full_q;
    if (cmd_i.disp_rd) begin
      old_id_q   <= cur_id_q;
      old_prio_q <= cur_prio_q;
    end
    if (cmd_i.disp_done) begin
      cur_id_q   <= head_q[hp];
      cur_prio_q <= hp;
      cur_time_q <= full_q;
      if (head_q[hp] != tail_q[hp]) head_q[hp] <= next_rdata;
    end
    if (ins_en) begin
      tail_q[ins_prio] <= ins_id;
      if (!ne_q[ins_prio]) head_q[ins_prio] <= ins_id;
    end
    if (cmd_i.out_load) begin
      o_status_q <= status_q;
      o_rvalid_q <= cur_valid_q;
      o_rid_q    <= cur_valid_q ? cur_id_q : '0;
      o_rstate_q <= cur_valid_q ? TstRunning : '0;
      o_new_id_q <= new_id_q;
      o_woken_q  <= woken_q;
    end
  end

  // Status to the controller.
  always_comb begin
    stat_o            = '0;
    stat_o.req        = req_q;
    stat_o.bad_prio   = (prio_q > PrioW'(MaxPrio));
    stat_o.full       = (thread_count_q >= CntW'(MaxThreads));
    stat_o.bad_ev     = ({1'b0, ev_q} >= num_events_q);
    stat_o.cur_valid  = cur_valid_q;
    stat_o.yielding   = yield_q;
    stat_o.rdy_any    = (ne_q != '0);
    stat_o.preempt    = (ne_q != '0) &&
                        ((hp > cur_prio_q) || (cur_time_q == '0 && cur_prio_q <= hp));
    stat_o.scan_more  = (scan_idx_q < wait_count_q);
    stat_o.reins_pend = reins_q;
    stat_o.out_free   = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = o_status_q;
  assign running_valid_o = o_rvalid_q;
  assign running_id_o    = o_rid_q;
  assign running_state_o = o_rstate_q;
  assign new_id_o        = o_new_id_q;
  assign woken_count_o   = o_woken_q;

endmodule
`default_nettype wire

/* design/priority_round_robin_scheduler_core.sv */
// Top level of the preemptive priority round-robin thread scheduler.
//
//   Channel | Handshake                  | Payload
//   --------+----------------------------+---------------------------------------------
//   request | in_valid_i / in_stall_o    | req_type_i, priority_req_i, event_id_i
//   result  | out_valid_o / out_stall_i  | status_o, running_valid_o, running_id_o,
//           |                            | running_state_o, new_id_o, woken_count_o
//   config  | cfg_we_i                   | cfg_index_i, cfg_data_i
//
// A signal request walks the wait list entry by entry through its registered-read RAM,
// with a read state and then a check state for each entry.
// One request is worked on at a time; the result register lets the next request in
// while the previous result waits. Reset clears all control state at once, with no
// clearing pass. A stalled result holds the last step until it is taken.
`default_nettype none
module priority_round_robin_scheduler_core (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [prrs_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [prrs_pkg::CfgW-1:0]    cfg_data_i,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [prrs_pkg::ReqW-1:0]    req_type_i,
  input  wire logic [prrs_pkg::PrioW-1:0]   priority_req_i,
  input  wire logic [prrs_pkg::EvW-1:0]     event_id_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic      [prrs_pkg::StatW-1:0]   status_o,
  output logic                              running_valid_o,
  output logic      [prrs_pkg::TidW-1:0]    running_id_o,
  output logic      [prrs_pkg::TstW-1:0]    running_state_o,
  output logic      [prrs_pkg::TidW-1:0]    new_id_o,
  output logic      [prrs_pkg::CntW-1:0]    woken_count_o
);
  import prrs_pkg::*;

  prrs_cmd_t  cmd;
  prrs_stat_t stat;

  // Request sequencer.
  prrs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Scheduler state and result register.
  prrs_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .req_type_i      (req_type_i),
    .priority_req_i  (priority_req_i),
    .event_id_i      (event_id_i),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .status_o        (status_o),
    .running_valid_o (running_valid_o),
    .running_id_o    (running_id_o),
    .running_state_o (running_state_o),
    .new_id_o        (new_id_o),
    .woken_count_o   (woken_count_o),
    .cmd_i           (cmd),
    .stat_o          (stat)
  );

endmodule
`default_nettype wire

/* test/priority_round_robin_scheduler_core_tb.sv */
// Self-checking testbench of the priority round-robin thread scheduler core.
`default_nettype none
module priority_round_robin_scheduler_core_tb;
  import prrs_pkg::*;

  typedef enum logic [ReqW-1:0] {
    ReqCreate = 3'd0, ReqTick = 3'd1, ReqWait = 3'd2, ReqSignal = 3'd3, ReqFinish = 3'd4,
    ReqUnused5 = 3'd5, ReqUnused6 = 3'd6, ReqUnused7 = 3'd7
  } req_e;

  typedef enum logic [StatW-1:0] {
    StOk = 2'd0, StBadPrio = 2'd1, StBadEvent = 2'd2, StFull = 2'd3
  } status_e;

  typedef enum logic [TstW-1:0] {
    ThNew = 3'd0, ThReady = 3'd1, ThRunning = 3'd2, ThWaiting = 3'd3, ThTerminated = 3'd4
  } thread_state_e;

  typedef enum logic [CfgIdxW-1:0] {RegQuantum = 1'b0, RegNumEvents = 1'b1} reg_e;

  typedef struct packed {
    logic [ReqW-1:0]  req;
    logic [PrioW-1:0] prio;
    logic [EvW-1:0]   ev;
  } request_t;

  typedef struct packed {
    logic [StatW-1:0] status;
    logic             run_valid;
    logic [TidW-1:0]  run_id;
    logic [TstW-1:0]  run_state;
    logic [TidW-1:0]  new_id;
    logic [CntW-1:0]  woken;
  } sched_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  request_t cur_req = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  sched_result_t dut_res;

  always #1 clk = ~clk;

  priority_round_robin_scheduler_core i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .req_type_i     (cur_req.req),
    .priority_req_i (cur_req.prio),
    .event_id_i     (cur_req.ev),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .status_o       (dut_res.status),
    .running_valid_o(dut_res.run_valid),
    .running_id_o   (dut_res.run_id),
    .running_state_o(dut_res.run_state),
    .new_id_o       (dut_res.new_id),
    .woken_count_o  (dut_res.woken)
  );

  // Scheduler state as predicted from the accepted requests.
  logic [PrioW-1:0]  th_prio [MaxThreads];
  logic [QuantW-1:0] th_time [MaxThreads];
  logic [TstW-1:0]   th_state[MaxThreads];
  logic [EvW-1:0]    th_event[MaxThreads];
  int ready_q[MaxThreads];
  int ready_n = 0;
  int wait_q[MaxThreads];
  int wait_n = 0;
  int threads_made = 0;
  int run_id = 0;
  bit run_valid = 1'b0;
  int unsigned quantum_reg = 1;
  int unsigned num_events_reg = 256;

  request_t      pending_reqs[$];
  sched_result_t expected_results[$];
  int errors = 0;
  int accepted_reqs = 0;
  int taken_results = 0;

  function automatic logic [QuantW-1:0] refill_value();
    return QuantW'(quantum_reg == 0 ? 1 : quantum_reg);
  endfunction

  // Sorted insert: behind all threads of equal or higher priority.
  function automatic void ready_insert(int id);
    int pos;
    pos = 0;
    if (ready_n >= MaxThreads) return;
    while (pos < ready_n && th_prio[ready_q[pos]] >= th_prio[id]) pos++;
    for (int k = ready_n; k > pos; k--) ready_q[k] = ready_q[k-1];
    ready_q[pos] = id;
    ready_n++;
  endfunction

  function automatic void dispatch_head();
    int id;
    id = ready_q[0];
    for (int k = 0; k + 1 < ready_n; k++) ready_q[k] = ready_q[k+1];
    ready_n--;
    th_time[id]  = refill_value();
    th_state[id] = ThRunning;
    run_id       = id;
    run_valid    = 1'b1;
  endfunction

  function automatic void pick_next();
    int r;
    if (!run_valid) begin
      if (ready_n > 0) dispatch_head();
      return;
    end
    r = run_id;
    if (th_state[r] == ThWaiting || th_state[r] == ThTerminated) begin
      if (ready_n > 0) dispatch_head();
      else run_valid = 1'b0;
      return;
    end
    if (ready_n > 0 && (th_prio[ready_q[0]] > th_prio[r] ||
        (th_time[r] == 0 && th_prio[r] <= th_prio[ready_q[0]]))) begin
      dispatch_head();
      th_state[r] = ThReady;
      ready_insert(r);
      return;
    end
    if (th_time[r] == 0) th_time[r] = refill_value();
  endfunction

  function automatic void spend_unit();
    if (run_valid && th_time[run_id] > 0) th_time[run_id]--;
    pick_next();
  endfunction

  function automatic bit event_valid(logic [EvW-1:0] ev);
    int unsigned lim;
    lim = num_events_reg < MaxEvents ? num_events_reg : MaxEvents;
    return ev < lim;
  endfunction

  function automatic sched_result_t schedule_step(request_t rq);
    sched_result_t res;
    int kept;
    int id;
    res = '0;
    case (rq.req)
      ReqCreate: begin
        if (rq.prio > MaxPrio) res.status = StBadPrio;
        else if (threads_made >= MaxThreads) res.status = StFull;
        else begin
          id = threads_made;
          res.new_id   = TidW'(id);
          th_prio[id]  = rq.prio;
          th_time[id]  = refill_value();
          th_state[id] = ThNew;
          th_event[id] = '0;
          threads_made++;
          ready_insert(id);
          spend_unit();
        end
      end
      ReqTick: if (run_valid) spend_unit();
      ReqWait: begin
        if (!event_valid(rq.ev)) res.status = StBadEvent;
        else if (run_valid) begin
          th_event[run_id] = rq.ev;
          th_state[run_id] = ThWaiting;
          if (wait_n < MaxThreads) wait_q[wait_n++] = run_id;
          spend_unit();
        end
      end
      ReqSignal: begin
        if (!event_valid(rq.ev)) res.status = StBadEvent;
        else begin
          kept = 0;
          for (int i = 0; i < wait_n; i++) begin
            id = wait_q[i];
            if (th_state[id] == ThWaiting && th_event[id] == rq.ev) begin
              th_state[id] = ThReady;
              ready_insert(id);
              res.woken++;
            end else begin
              wait_q[kept++] = id;
            end
          end
          wait_n = kept;
          spend_unit();
        end
      end
      ReqFinish: begin
        if (run_valid) begin
          th_state[run_id] = ThTerminated;
          pick_next();
        end
      end
      default: ;
    endcase
    res.run_valid = run_valid;
    res.run_id    = run_valid ? TidW'(run_id) : '0;
    res.run_state = run_valid ? th_state[run_id] : '0;
    return res;
  endfunction

  // Both sides run without gaps for a stretch in the middle of the run.
  function automatic bit pick_idle();
    if (accepted_reqs >= 700 && accepted_reqs < 900) return 1'b0;
    return $urandom_range(99) < 26;
  endfunction

  // Driver: predicts each accepted transaction and presents the next request.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(schedule_step(cur_req));
        accepted_reqs++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_reqs.size() > 0 && !pick_idle()) begin
          cur_req  <= pending_reqs.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks results and applies receiver back-pressure.
  int hold_cycles = 0;
  always @(posedge clk) begin
    sched_result_t exp_res;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        taken_results++;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %p", $time, dut_res);
          errors++;
        end else begin
          exp_res = expected_results.pop_front();
          if (exp_res.status !== dut_res.status) begin
            $display("%0t: status expected %0d actual %0d", $time, exp_res.status,
                     dut_res.status);
            errors++;
          end
          if (exp_res.run_valid !== dut_res.run_valid) begin
            $display("%0t: running_valid expected %0d actual %0d", $time,
                     exp_res.run_valid, dut_res.run_valid);
            errors++;
          end
          if (exp_res.run_id !== dut_res.run_id) begin
            $display("%0t: running_id expected %0d actual %0d", $time, exp_res.run_id,
                     dut_res.run_id);
            errors++;
          end
          if (exp_res.run_state !== dut_res.run_state) begin
            $display("%0t: running_state expected %0d actual %0d", $time,
                     exp_res.run_state, dut_res.run_state);
            errors++;
          end
          if (exp_res.new_id !== dut_res.new_id) begin
            $display("%0t: new_id expected %0d actual %0d", $time, exp_res.new_id,
                     dut_res.new_id);
            errors++;
          end
          if (exp_res.woken !== dut_res.woken) begin
            $display("%0t: woken_count expected %0d actual %0d", $time, exp_res.woken,
                     dut_res.woken);
            errors++;
          end
        end
      end
      // A long hold-off once, so that the block fills and stalls its input.
      if (taken_results == 150 && hold_cycles == 0 && out_valid && !out_stall) begin
        hold_cycles = 500;
      end
      if (hold_cycles > 1) begin
        hold_cycles--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= pick_idle();
      end
    end
  end

  task automatic write_reg(reg_e idx, int unsigned value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CfgW'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == RegQuantum) quantum_reg = value & 16'hFFFF;
    else num_events_reg = value & 9'h1FF;
  endtask

  task automatic push_req(req_e rq, int prio, int ev);
    request_t item;
    item.req  = rq;
    item.prio = PrioW'(prio);
    item.ev   = EvW'(ev);
    pending_reqs.push_back(item);
  endtask

  task automatic drain();
    while (pending_reqs.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Random request mix, biased toward a few events so that signals wake threads.
  task automatic push_random(int count);
    int r;
    int ev;
    for (int n = 0; n < count; n++) begin
      r  = $urandom_range(99);
      ev = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(3);
      if (r < 5) push_req(ReqCreate, $urandom_range(7), $urandom_range(255));
      else if (r < 50) push_req(ReqTick, $urandom_range(7), $urandom_range(255));
      else if (r < 67) push_req(ReqWait, $urandom_range(7), ev);
      else if (r < 85) push_req(ReqSignal, $urandom_range(7), ev);
      else if (r < 88) push_req(ReqFinish, $urandom_range(7), $urandom_range(255));
      else if (r < 91) push_req(req_e'($urandom_range(7, 5)), $urandom_range(7),
                                $urandom_range(255));
      else push_req(ReqTick, $urandom_range(7), $urandom_range(255));
    end
  endtask

  int unsigned quantum_set[6]    = '{1, 0, 3, 65535, 2, 5};
  int unsigned num_events_set[6] = '{256, 4, 1, 255, 0, 256};

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    write_reg(RegQuantum, 2);
    write_reg(RegNumEvents, 256);

    // Directed part: idle processor, creates, bad fields, waits, signals and finish.
    push_req(ReqTick, 0, 0);
    push_req(ReqWait, 0, 0);
    push_req(ReqFinish, 0, 0);
    push_req(ReqSignal, 0, 255);
    push_req(ReqCreate, 6, 0);
    push_req(ReqCreate, 7, 255);
    push_req(ReqCreate, 0, 0);
    push_req(ReqCreate, 0, 0);
    push_req(ReqTick, 0, 0);
    push_req(ReqTick, 0, 0);
    push_req(ReqCreate, 5, 0);
    push_req(ReqWait, 0, 255);
    push_req(ReqWait, 0, 7);
    push_req(ReqWait, 0, 7);
    push_req(ReqSignal, 0, 7);
    push_req(ReqCreate, 3, 0);
    push_req(ReqTick, 0, 0);
    push_req(ReqFinish, 0, 0);
    push_req(ReqUnused5, 7, 255);
    push_req(ReqUnused6, 0, 0);
    push_req(ReqUnused7, 5, 128);
    push_req(ReqTick, 0, 0);
    drain();

    // Random phases, each under its own register setting.
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(RegQuantum, quantum_set[ph]);
      write_reg(RegNumEvents, num_events_set[ph]);
      push_random(300);
      drain();
    end

    repeat (200) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("** priority_round_robin_scheduler_core: PASSED **");
    end else begin
      $display("** priority_round_robin_scheduler_core: FAILED **");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #6000000;
    $display("** priority_round_robin_scheduler_core: FAILED **");
    $finish;
  end

endmodule
`default_nettype wire
